// ----- rtl/i2cms_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cms_pkg: shared types and codes of the I2C master transfer sequencer
// Item and result layouts, operation classes, phases and status codes.
// ----------------------------------------------------------------------------
package i2cms_pkg;

	// function codes of an input beat
	localparam logic [2:0] FN_LOAD      = 3'd0;
	localparam logic [2:0] FN_WRITE     = 3'd1;
	localparam logic [2:0] FN_READ      = 3'd2;
	localparam logic [2:0] FN_WRITE_RD  = 3'd3;
	localparam logic [2:0] FN_STATUS    = 3'd4;

	// two-wire status codes
	localparam logic [7:0] ST_START        = 8'h08;
	localparam logic [7:0] ST_REP_START    = 8'h10;
	localparam logic [7:0] ST_MT_SLA_ACK   = 8'h18;
	localparam logic [7:0] ST_MT_DATA_ACK  = 8'h28;
	localparam logic [7:0] ST_MR_SLA_ACK   = 8'h40;
	localparam logic [7:0] ST_MR_DATA_ACK  = 8'h50;
	localparam logic [7:0] ST_MR_DATA_NACK = 8'h58;

	// direction bit, also bit 0 of the address byte
	localparam logic DIR_TX = 1'b0;
	localparam logic DIR_RX = 1'b1;

	// progress codes
	localparam logic [1:0] PROG_IDLE  = 2'd0;
	localparam logic [1:0] PROG_BUSY  = 2'd1;
	localparam logic [1:0] PROG_DONE  = 2'd2;
	localparam logic [1:0] PROG_ERROR = 2'd3;

	typedef enum logic [2:0] {
		PH_IDLE      = 3'd0,
		PH_START     = 3'd1,
		PH_SEND_ADDR = 3'd2,
		PH_SEND_DATA = 3'd3,
		PH_RECV_DATA = 3'd4,
		PH_STOP      = 3'd5,
		PH_DONE      = 3'd6,
		PH_ERROR     = 3'd7
	} phase_t;

	typedef enum logic [1:0] {
		OP_NONE   = 2'd0,
		OP_LOAD   = 2'd1,
		OP_START  = 2'd2,
		OP_STATUS = 2'd3
	} op_t;

	typedef struct packed {
		logic [2:0] func;
		logic [7:0] addr_byte;
		logic [4:0] tx_len;
		logic [4:0] rx_len;
		logic [3:0] buf_index;
		logic [7:0] data_byte;
		logic [7:0] bus_status;
	} in_item_t;

	typedef struct packed {
		logic       issue_start;
		logic       issue_stop;
		logic       ack_next;
		logic       keep_interrupt;
		logic [7:0] send_byte;
		logic       send_valid;
		logic [7:0] recv_byte;
		logic       recv_valid;
		logic [3:0] recv_slot;
		logic [1:0] progress;
	} out_item_t;

	// classified item as it sits in the queue
	typedef struct packed {
		op_t        op;
		logic [7:0] addr;
		logic [4:0] tx_cnt;
		logic [4:0] rx_rem;
		logic       rd_fol;
		logic       dir;
		logic       wr_ok;
		logic [3:0] idx;
		logic [7:0] data;
		logic [7:0] status;
	} work_t;

endpackage

// ----- rtl/i2cms_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cms_if: valid/ready channels of the I2C master transfer sequencer
// Command channel into the block and result channel out of it.
// ----------------------------------------------------------------------------
interface i2cms_in_if;
	import i2cms_pkg::*;
	logic     valid;
	logic     ready;
	in_item_t payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

interface i2cms_out_if;
	import i2cms_pkg::*;
	logic      valid;
	logic      ready;
	out_item_t payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// ----- rtl/i2c_master_transfer_sequencer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2c_master_transfer_sequencer: I2C master transfer sequencer
// Turns load, start and bus status beats into bus commands and results.
// ----------------------------------------------------------------------------
// Every command beat yields exactly one result beat, in order. The block takes
// one beat per clock while results are taken: decode is combinational in front
// of a two-entry queue, the sequencer finishes one queued beat per cycle unless
// its output register holds a result not yet taken, and parks its result there,
// so a result passes the queue register and then the output register. The input
// side keeps accepting while a result waits, until the queue is full. Load beats
// fill the transmit store (min(BUF_DEPTH,16) one-byte slots); start beats (write,
// read, write then read) abort any running transfer and request a start; status
// beats advance the transfer phase. Lengths are clamped to 1..min(BUF_DEPTH,31).
// A status that does not fit the current phase reports error and requests a
// stop. Transmit slots that were never loaded read back as arbitrary data.
// ----------------------------------------------------------------------------
module i2c_master_transfer_sequencer #(
	parameter int BUF_DEPTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	i2cms_in_if.sink    cmd,
	i2cms_out_if.source rsp
);
	import i2cms_pkg::*;

	// the load slot field is four bits wide, so no slot above 15 is ever filled
	localparam int STORE_DEPTH = (BUF_DEPTH < 16) ? BUF_DEPTH : 16;
	localparam int IDX_W       = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

	logic  fq_valid, fq_ready;
	work_t fq_item;
	logic  qb_valid, qb_ready;
	work_t qb_item;

	// front: classify and clamp
	i2cms_front #(
		.BUF_DEPTH(BUF_DEPTH)
	) u_front (
		.cmd    (cmd),
		.q_ready(fq_ready),
		.q_valid(fq_valid),
		.q_item (fq_item)
	);

	// decoupling queue
	i2cms_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_valid(fq_valid),
		.push_ready(fq_ready),
		.push_item (fq_item),
		.pop_valid (qb_valid),
		.pop_ready (qb_ready),
		.pop_item  (qb_item)
	);

	// back: phase sequencer, transmit store, result register
	i2cms_back #(
		.STORE_DEPTH(STORE_DEPTH),
		.IDX_W      (IDX_W)
	) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.q_valid(qb_valid),
		.q_ready(qb_ready),
		.q_item (qb_item),
		.rsp    (rsp)
	);

endmodule

// ----- rtl/i2cms_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cms_front: command decode
// Classifies each beat, clamps lengths and checks the load slot.
// ----------------------------------------------------------------------------
module i2cms_front #(
	parameter int BUF_DEPTH = 16
) (
	i2cms_in_if.sink        cmd,
	input  logic            q_ready,
	output logic            q_valid,
	output i2cms_pkg::work_t q_item
);
	import i2cms_pkg::*;

	localparam int LEN_MAX = (BUF_DEPTH > 31) ? 31 : BUF_DEPTH;

	function automatic logic [4:0] clamp_len(input logic [4:0] len);
		logic [4:0] r;
		if (len == 5'd0)
			r = 5'd1;
		else if (len > 5'(LEN_MAX))
			r = 5'(LEN_MAX);
		else
			r = len;
		return r;
	endfunction

	assign cmd.ready = q_ready;
	assign q_valid   = cmd.valid;

	always_comb begin
		q_item        = '0;
		q_item.addr   = cmd.payload.addr_byte;
		q_item.idx    = cmd.payload.buf_index;
		q_item.data   = cmd.payload.data_byte;
		q_item.status = cmd.payload.bus_status;
		q_item.wr_ok  = (int'(cmd.payload.buf_index) < BUF_DEPTH);
		q_item.rd_fol = (cmd.payload.func == FN_WRITE_RD);
		q_item.dir    = (cmd.payload.func == FN_READ) ? DIR_RX : DIR_TX;
		q_item.tx_cnt = (cmd.payload.func == FN_READ) ? 5'd0 : clamp_len(cmd.payload.tx_len);
		q_item.rx_rem = (cmd.payload.func == FN_WRITE) ? 5'd0 : clamp_len(cmd.payload.rx_len);
		unique case (cmd.payload.func)
			FN_LOAD:                        q_item.op = OP_LOAD;
			FN_WRITE, FN_READ, FN_WRITE_RD: q_item.op = OP_START;
			FN_STATUS:                      q_item.op = OP_STATUS;
			default:                        q_item.op = OP_NONE;
		endcase
	end

endmodule

// ----- rtl/i2cms_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cms_queue: two-entry queue between decode and sequencer
// Registered FIFO; each side stalls on its own.
// ----------------------------------------------------------------------------
module i2cms_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push_valid,
	output logic             push_ready,
	input  i2cms_pkg::work_t push_item,
	output logic             pop_valid,
	input  logic             pop_ready,
	output i2cms_pkg::work_t pop_item
);
	import i2cms_pkg::*;

	work_t      ent_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	logic       push;
	logic       pop;

	assign push_ready = (cnt_q != 2'd2);
	assign pop_valid  = (cnt_q != 2'd0);
	assign pop_item   = ent_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (push)
			ent_q[wr_ptr_q] <= push_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push)
				wr_ptr_q <= ~wr_ptr_q;
			if (pop)
				rd_ptr_q <= ~rd_ptr_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 2'd2) |-> !push)
		else $error("queue push while full");
	a_count_track: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> (cnt_q == $past(cnt_q) + 2'd1))
		else $error("queue count lost a push");
	a_ptr_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 2'd1) |-> (wr_ptr_q != rd_ptr_q))
		else $error("queue pointers out of step");

endmodule

// ----- rtl/i2cms_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cms_back: transfer sequencer
// Steps the transfer phase one queued item per cycle while results are taken,
// holds the transmit store and registers each result beat.
// ----------------------------------------------------------------------------
module i2cms_back #(
	parameter int STORE_DEPTH = 16,
	parameter int IDX_W       = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             q_valid,
	output logic             q_ready,
	input  i2cms_pkg::work_t q_item,
	i2cms_out_if.source      rsp
);
	import i2cms_pkg::*;

	phase_t     phase_q, phase_nxt;
	logic       dir_q, dir_nxt;
	logic [7:0] addr_q, addr_nxt;
	logic [4:0] tx_pos_q, tx_pos_nxt;
	logic [4:0] tx_cnt_q, tx_cnt_nxt;
	logic [4:0] rx_rem_q, rx_rem_nxt;
	logic [4:0] rx_pos_q, rx_pos_nxt;
	logic       rd_fol_q, rd_fol_nxt;
	logic [7:0] store_q [STORE_DEPTH];
	logic [IDX_W-1:0] rd_idx;
	logic [7:0] rd_byte;
	out_item_t  res;
	out_item_t  out_q;
	logic       out_vld_q;
	logic       step;
	logic       bad;

	assign q_ready     = !out_vld_q || rsp.ready;
	assign step        = q_valid && q_ready;
	assign rsp.valid   = out_vld_q;
	assign rsp.payload = out_q;

	// first data byte comes from slot 0, later ones from the running position
	assign rd_idx  = (phase_q == PH_SEND_ADDR) ? '0 : tx_pos_q[IDX_W-1:0];
	assign rd_byte = store_q[rd_idx];

	always_ff @(posedge clk) begin
		if (step && q_item.op == OP_LOAD && q_item.wr_ok)
			store_q[q_item.idx[IDX_W-1:0]] <= q_item.data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			dir_q    <= DIR_TX;
			addr_q   <= 8'd0;
			tx_pos_q <= 5'd0;
			tx_cnt_q <= 5'd0;
			rx_rem_q <= 5'd0;
			rx_pos_q <= 5'd0;
			rd_fol_q <= 1'b0;
		end else if (step) begin
			phase_q  <= phase_nxt;
			dir_q    <= dir_nxt;
			addr_q   <= addr_nxt;
			tx_pos_q <= tx_pos_nxt;
			tx_cnt_q <= tx_cnt_nxt;
			rx_rem_q <= rx_rem_nxt;
			rx_pos_q <= rx_pos_nxt;
			rd_fol_q <= rd_fol_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_vld_q <= 1'b0;
		else if (step)
			out_vld_q <= 1'b1;
		else if (rsp.ready)
			out_vld_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (step)
			out_q <= res;
	end

	always_comb begin
		phase_nxt  = phase_q;
		dir_nxt    = dir_q;
		addr_nxt   = addr_q;
		tx_pos_nxt = tx_pos_q;
		tx_cnt_nxt = tx_cnt_q;
		rx_rem_nxt = rx_rem_q;
		rx_pos_nxt = rx_pos_q;
		rd_fol_nxt = rd_fol_q;
		res        = '0;
		bad        = 1'b0;
		unique case (q_item.op)
			OP_START: begin
				addr_nxt           = q_item.addr;
				phase_nxt          = PH_START;
				tx_pos_nxt         = 5'd0;
				rx_pos_nxt         = 5'd0;
				rd_fol_nxt         = q_item.rd_fol;
				dir_nxt            = q_item.dir;
				tx_cnt_nxt         = q_item.tx_cnt;
				rx_rem_nxt         = q_item.rx_rem;
				res.issue_start    = 1'b1;
				res.keep_interrupt = 1'b1;
			end
			OP_STATUS: begin
				unique case (phase_q)
					PH_START: begin
						if (q_item.status == ST_START || q_item.status == ST_REP_START) begin
							phase_nxt          = PH_SEND_ADDR;
							res.send_byte      = {addr_q[7:1], dir_q};
							res.send_valid     = 1'b1;
							res.keep_interrupt = 1'b1;
						end else
							bad = 1'b1;
					end
					PH_SEND_ADDR: begin
						if (dir_q == DIR_TX && q_item.status == ST_MT_SLA_ACK) begin
							phase_nxt          = PH_SEND_DATA;
							tx_pos_nxt         = 5'd1;
							res.send_byte      = rd_byte;
							res.send_valid     = 1'b1;
							res.keep_interrupt = 1'b1;
						end else if (dir_q == DIR_RX && q_item.status == ST_MR_SLA_ACK) begin
							phase_nxt          = PH_RECV_DATA;
							rx_pos_nxt         = 5'd0;
							res.ack_next       = (rx_rem_q > 5'd1);
							res.keep_interrupt = 1'b1;
						end else
							bad = 1'b1;
					end
					PH_SEND_DATA: begin
						if (dir_q == DIR_TX && q_item.status == ST_MT_DATA_ACK) begin
							res.keep_interrupt = 1'b1;
							if (tx_pos_q < tx_cnt_q) begin
								res.send_byte  = rd_byte;
								res.send_valid = 1'b1;
								tx_pos_nxt     = tx_pos_q + 5'd1;
							end else if (rd_fol_q) begin
								// repeated start, then the read half
								rd_fol_nxt      = 1'b0;
								dir_nxt         = DIR_RX;
								phase_nxt       = PH_START;
								res.issue_start = 1'b1;
							end else begin
								phase_nxt      = PH_STOP;
								res.issue_stop = 1'b1;
							end
						end else
							bad = 1'b1;
					end
					PH_RECV_DATA: begin
						if (dir_q == DIR_RX && rx_rem_q != 5'd0 &&
								q_item.status == ((rx_rem_q > 5'd1) ? ST_MR_DATA_ACK
								: ST_MR_DATA_NACK)) begin
							res.recv_byte      = q_item.data;
							res.recv_valid     = 1'b1;
							res.recv_slot      = rx_pos_q[3:0];
							rx_pos_nxt         = rx_pos_q + 5'd1;
							rx_rem_nxt         = rx_rem_q - 5'd1;
							res.keep_interrupt = 1'b1;
							if (rx_rem_q > 5'd1)
								res.ack_next = (rx_rem_q > 5'd2);
							else begin
								phase_nxt      = PH_STOP;
								res.issue_stop = 1'b1;
							end
						end else
							bad = 1'b1;
					end
					PH_STOP: phase_nxt = PH_DONE;
					default: bad = 1'b1;
				endcase
				if (bad) begin
					phase_nxt          = PH_ERROR;
					res.issue_stop     = 1'b1;
					res.keep_interrupt = 1'b0;
				end
			end
			default: ;
		endcase
		unique case (phase_nxt)
			PH_IDLE:  res.progress = PROG_IDLE;
			PH_DONE:  res.progress = PROG_DONE;
			PH_ERROR: res.progress = PROG_ERROR;
			default:  res.progress = PROG_BUSY;
		endcase
	end

	a_recv_dir: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_RECV_DATA) |-> (dir_q == DIR_RX))
		else $error("receive phase in transmit direction");
	a_send_dir: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_SEND_DATA) |-> (dir_q == DIR_TX && tx_pos_q <= tx_cnt_q))
		else $error("send phase out of bounds");
	a_recv_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(out_vld_q && out_q.recv_valid) |-> (out_q.progress == PROG_BUSY))
		else $error("received byte outside a busy transfer");
	a_err_stop: assert property (@(posedge clk) disable iff (!arst_n)
		(step && phase_nxt == PH_ERROR && phase_q != PH_ERROR) |=>
		(out_q.issue_stop && !out_q.keep_interrupt))
		else $error("error entry without stop");

endmodule

// ----- test/i2c_master_transfer_sequencer_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2c_master_transfer_sequencer_tb: self-checking bench for the I2C sequencer
// Drives load, start and bus status beats into the command channel. A built-in
// predictor follows the transfer phases and gives the expected response for
// each accepted beat. Responses are checked field by field and in order.
// Stimulus is a short directed part followed by well-formed random transfers
// with some noise, under several sender and receiver idle mixes. One long
// receiver hold-off makes the block fill up and stall its input.
// ----------------------------------------------------------------------------
module i2c_master_transfer_sequencer_tb;
	import i2cms_pkg::*;

	localparam int DEPTH       = 16;
	localparam int HOLD_CYCLES = 80;    // long receiver hold-off
	localparam int DRAIN_LIMIT = 5000;  // cycles allowed for the last responses
	localparam int TAIL_CYCLES = 20;    // quiet cycles after the drain
	localparam int MAX_REPORTS = 10;

	logic clk;
	logic arst_n;

	i2cms_in_if  cmd ();
	i2cms_out_if rsp ();

	i2c_master_transfer_sequencer #(
		.BUF_DEPTH(DEPTH)
	) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.rsp    (rsp)
	);

	// ------------------------------------------------------------------------
	// Predictor state: a private copy of the sequencer's registers
	// ------------------------------------------------------------------------
	phase_t     seq_phase;
	logic       seq_dir;
	logic [7:0] seq_addr;
	logic [7:0] tx_bytes [DEPTH];
	logic [4:0] tx_pos;
	logic [4:0] tx_total;
	logic [4:0] rx_left;
	logic [4:0] rx_pos;
	logic       then_read;
	// slots loaded since reset; a write transfer never reaches past these
	logic [DEPTH-1:0] slot_loaded;

	out_item_t pending_responses [$];

	int error_count;
	int result_count;

	// traffic shaping; idle and stall percentages change only between test phases
	int idle_pct;
	int stall_pct;
	bit hold_req;
	int hold_left;

	// ------------------------------------------------------------------------
	// Clock, reset
	// ------------------------------------------------------------------------
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Global watchdog. Far above the slowest legal run, so it only fires when the
	// block hangs or loses a response.
	initial begin
		#400000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// ------------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------------
	function automatic logic [4:0] fit_len(input logic [4:0] n);
		if (n == 5'd0)
			return 5'd1;
		if (n > 5'(DEPTH))
			return 5'(DEPTH);
		return n;
	endfunction

	function automatic logic [1:0] progress_code(input phase_t ph);
		case (ph)
			PH_IDLE:  return PROG_IDLE;
			PH_DONE:  return PROG_DONE;
			PH_ERROR: return PROG_ERROR;
			default:  return PROG_BUSY;
		endcase
	endfunction

	// Applies one bus status event to the predictor state.
	function automatic out_item_t status_response(input logic [7:0] st, input logic [7:0] data);
		out_item_t r;
		bit        fits;
		r    = '0;
		fits = 1'b0;
		case (seq_phase)
			PH_START: begin
				if (st == ST_START || st == ST_REP_START) begin
					seq_phase        = PH_SEND_ADDR;
					r.send_byte      = {seq_addr[7:1], seq_dir};
					r.send_valid     = 1'b1;
					r.keep_interrupt = 1'b1;
					fits             = 1'b1;
				end
			end
			PH_SEND_ADDR: begin
				if (seq_dir == DIR_TX && st == ST_MT_SLA_ACK) begin
					seq_phase        = PH_SEND_DATA;
					tx_pos           = 5'd1;
					r.send_byte      = tx_bytes[0];
					r.send_valid     = 1'b1;
					r.keep_interrupt = 1'b1;
					fits             = 1'b1;
				end else if (seq_dir == DIR_RX && st == ST_MR_SLA_ACK) begin
					seq_phase        = PH_RECV_DATA;
					rx_pos           = 5'd0;
					r.ack_next       = (rx_left > 5'd1);
					r.keep_interrupt = 1'b1;
					fits             = 1'b1;
				end
			end
			PH_SEND_DATA: begin
				if (seq_dir == DIR_TX && st == ST_MT_DATA_ACK) begin
					r.keep_interrupt = 1'b1;
					fits             = 1'b1;
					if (tx_pos < tx_total && tx_pos < 5'(DEPTH)) begin
						r.send_byte  = tx_bytes[tx_pos[3:0]];
						r.send_valid = 1'b1;
						tx_pos++;
					end else if (then_read) begin
						// repeated start, then the read half
						then_read     = 1'b0;
						seq_dir       = DIR_RX;
						seq_phase     = PH_START;
						r.issue_start = 1'b1;
					end else begin
						seq_phase    = PH_STOP;
						r.issue_stop = 1'b1;
					end
				end
			end
			PH_RECV_DATA: begin
				if (seq_dir == DIR_RX && rx_left >= 5'd1 &&
						st == ((rx_left > 5'd1) ? ST_MR_DATA_ACK : ST_MR_DATA_NACK)) begin
					r.recv_byte      = data;
					r.recv_valid     = 1'b1;
					r.recv_slot      = rx_pos[3:0];
					r.keep_interrupt = 1'b1;
					fits             = 1'b1;
					rx_pos++;
					rx_left--;
					if (rx_left > 5'd0) begin
						r.ack_next = (rx_left > 5'd1);
					end else begin
						seq_phase    = PH_STOP;
						r.issue_stop = 1'b1;
					end
				end
			end
			PH_STOP: begin
				// any status closes the transfer
				seq_phase = PH_DONE;
				fits      = 1'b1;
			end
			default: ;
		endcase
		if (!fits) begin
			seq_phase        = PH_ERROR;
			r.issue_stop     = 1'b1;
			r.keep_interrupt = 1'b0;
		end
		return r;
	endfunction

	// Expected response of one accepted command beat; updates the state.
	function automatic out_item_t bus_response(input in_item_t it);
		out_item_t r;
		r = '0;
		case (it.func)
			FN_LOAD: begin
				// buf_index cannot exceed the store at this depth
				tx_bytes[it.buf_index]    = it.data_byte;
				slot_loaded[it.buf_index] = 1'b1;
			end
			FN_WRITE, FN_READ, FN_WRITE_RD: begin
				// a start always aborts whatever runs
				seq_addr  = it.addr_byte;
				seq_phase = PH_START;
				tx_pos    = 5'd0;
				rx_pos    = 5'd0;
				then_read = (it.func == FN_WRITE_RD);
				seq_dir   = (it.func == FN_READ) ? DIR_RX : DIR_TX;
				tx_total  = (it.func == FN_READ) ? 5'd0 : fit_len(it.tx_len);
				rx_left   = (it.func == FN_WRITE) ? 5'd0 : fit_len(it.rx_len);
				r.issue_start    = 1'b1;
				r.keep_interrupt = 1'b1;
			end
			FN_STATUS: r = status_response(it.bus_status, it.data_byte);
			default: ;  // unused codes change nothing
		endcase
		r.progress = progress_code(seq_phase);
		return r;
	endfunction

	// ------------------------------------------------------------------------
	// Command side
	// ------------------------------------------------------------------------
	// One command beat. Optional idle cycles first, then valid stays up until
	// the beat is taken; the prediction is made at the accepting edge.
	task automatic send_cmd(input in_item_t it);
		if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
			cmd.valid <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(99) < idle_pct);
		end
		cmd.valid   <= 1'b1;
		cmd.payload <= it;
		do
			@(posedge clk);
		while (cmd.ready !== 1'b1);
		pending_responses.push_back(bus_response(it));
	endtask

	// Unused fields of every beat carry random bits.
	function automatic in_item_t noise_item();
		in_item_t    it;
		logic [63:0] raw;
		raw = {$urandom, $urandom};
		it  = raw[$bits(in_item_t)-1:0];
		return it;
	endfunction

	task automatic send_load(input logic [3:0] idx, input logic [7:0] data);
		in_item_t it;
		it           = noise_item();
		it.func      = FN_LOAD;
		it.buf_index = idx;
		it.data_byte = data;
		send_cmd(it);
	endtask

	task automatic send_start(input logic [2:0] fn, input logic [7:0] addr,
			input logic [4:0] txl, input logic [4:0] rxl);
		in_item_t it;
		it           = noise_item();
		it.func      = fn;
		it.addr_byte = addr;
		it.tx_len    = txl;
		it.rx_len    = rxl;
		send_cmd(it);
	endtask

	task automatic send_status(input logic [7:0] st, input logic [7:0] data);
		in_item_t it;
		it            = noise_item();
		it.func       = FN_STATUS;
		it.bus_status = st;
		it.data_byte  = data;
		send_cmd(it);
	endtask

	task automatic send_unused(input logic [2:0] fn);
		in_item_t it;
		it      = noise_item();
		it.func = fn;
		send_cmd(it);
	endtask

	// ------------------------------------------------------------------------
	// Response side
	// ------------------------------------------------------------------------
	// Receiver: random stalls, plus one long hold-off when asked for.
	initial begin
		rsp.ready = 1'b0;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_left = HOLD_CYCLES;
				hold_req  = 1'b0;
			end
			if (hold_left > 0) begin
				rsp.ready <= 1'b0;
				hold_left--;
			end else begin
				rsp.ready <= ($urandom_range(99) >= stall_pct);
			end
		end
	end

	task automatic note_error(input string msg);
		error_count++;
		if (error_count <= MAX_REPORTS)
			$display("[%0t] response %0d: %s", $realtime, result_count, msg);
	endtask

	task automatic check_field(input string name, input logic [7:0] want,
			input logic [7:0] got);
		if (got !== want)
			note_error($sformatf("%s expected 0x%02h got 0x%02h", name, want, got));
	endtask

	// Checker: every response beat against the oldest expectation.
	initial begin
		out_item_t want;
		out_item_t got;
		forever begin
			@(posedge clk);
			if (arst_n === 1'b1 && rsp.valid === 1'b1 && rsp.ready === 1'b1) begin
				got = rsp.payload;
				if (pending_responses.size() == 0) begin
					note_error("response with no command waiting");
				end else begin
					want = pending_responses.pop_front();
					check_field("issue_start", 8'(want.issue_start), 8'(got.issue_start));
					check_field("issue_stop", 8'(want.issue_stop), 8'(got.issue_stop));
					check_field("ack_next", 8'(want.ack_next), 8'(got.ack_next));
					check_field("keep_interrupt", 8'(want.keep_interrupt),
						8'(got.keep_interrupt));
					check_field("send_byte", want.send_byte, got.send_byte);
					check_field("send_valid", 8'(want.send_valid), 8'(got.send_valid));
					check_field("recv_byte", want.recv_byte, got.recv_byte);
					check_field("recv_valid", 8'(want.recv_valid), 8'(got.recv_valid));
					check_field("recv_slot", 8'(want.recv_slot), 8'(got.recv_slot));
					check_field("progress", 8'(want.progress), 8'(got.progress));
				end
				result_count++;
			end
		end
	end

	// ------------------------------------------------------------------------
	// Stimulus helpers for the random part
	// ------------------------------------------------------------------------
	// Mostly short lengths, now and then the full store or an oversize value.
	function automatic logic [4:0] pick_len();
		int r;
		r = $urandom_range(99);
		if (r < 70)
			return 5'($urandom_range(0, 4));
		if (r < 90)
			return 5'($urandom_range(5, 16));
		return 5'($urandom_range(17, 31));
	endfunction

	function automatic int loaded_prefix();
		int n;
		n = 0;
		while (n < DEPTH && slot_loaded[n])
			n++;
		return n;
	endfunction

	// Cut a write length back so the transfer only reads loaded slots.
	function automatic logic [4:0] safe_tx_len(input logic [4:0] raw);
		int pre;
		pre = loaded_prefix();
		if (int'(fit_len(raw)) <= pre)
			return raw;
		return 5'(pre);
	endfunction

	function automatic bit transfer_open();
		return !(seq_phase inside {PH_IDLE, PH_DONE, PH_ERROR});
	endfunction

	// The status a well-behaved bus would report next.
	function automatic logic [7:0] next_good_status();
		case (seq_phase)
			PH_START:     return $urandom_range(1) ? ST_REP_START : ST_START;
			PH_SEND_ADDR: return (seq_dir == DIR_TX) ? ST_MT_SLA_ACK : ST_MR_SLA_ACK;
			PH_SEND_DATA: return ST_MT_DATA_ACK;
			PH_RECV_DATA: return (rx_left > 5'd1) ? ST_MR_DATA_ACK : ST_MR_DATA_NACK;
			default:      return 8'($urandom);
		endcase
	endfunction

	// Half the loads fill the next empty slot so long writes open up early.
	task automatic load_random_slot();
		int pre;
		pre = loaded_prefix();
		if (pre < DEPTH && $urandom_range(1))
			send_load(4'(pre), 8'($urandom));
		else
			send_load(4'($urandom), 8'($urandom));
	endtask

	task automatic random_start();
		send_start(3'($urandom_range(FN_WRITE, FN_WRITE_RD)), 8'($urandom),
			safe_tx_len(pick_len()), pick_len());
	endtask

	// ------------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------------
	// Loads at both ends of the store, a status with no transfer, unused codes.
	task automatic test_idle_codes();
		send_load(4'd0, 8'h00);
		send_load(4'd15, 8'hFF);
		send_load(4'd1, 8'h5A);
		send_status(ST_START, 8'hFF);   // unexpected: nothing started
		send_unused(3'd5);
		send_unused(3'd7);
	endtask

	// Two-byte write: address, data, data, stop, close.
	task automatic test_write_transfer();
		send_start(FN_WRITE, 8'hFF, 5'd2, 5'd31);
		send_status(ST_START, 8'h00);
		send_status(ST_MT_SLA_ACK, 8'h00);
		send_status(ST_MT_DATA_ACK, 8'h00);
		send_status(ST_MT_DATA_ACK, 8'hFF);
		send_status(8'hFF, 8'h00);      // any status ends it
	endtask

	// Zero lengths clamp to one: one byte out, repeated start, one byte in.
	task automatic test_write_read_transfer();
		send_start(FN_WRITE_RD, 8'h00, 5'd0, 5'd0);
		send_status(ST_REP_START, 8'h00);
		send_status(ST_MT_SLA_ACK, 8'h00);
		send_status(ST_MT_DATA_ACK, 8'h00);
		send_status(ST_REP_START, 8'h00);
		send_status(ST_MR_SLA_ACK, 8'h00);
		send_status(ST_MR_DATA_NACK, 8'hFF);
		send_status(8'h00, 8'h00);
	endtask

	// Read cut short by a new start, then a status that does not fit.
	task automatic test_read_abort();
		send_start(FN_READ, 8'h80, 5'd2, 5'd2);
		send_status(ST_START, 8'h00);
		send_status(ST_MR_SLA_ACK, 8'h00);
		send_status(ST_MR_DATA_ACK, 8'h3C);
		send_start(FN_WRITE, 8'h81, 5'd1, 5'd0);
		send_status(ST_MR_DATA_NACK, 8'h00);
	endtask

	// Whole transfers with random content; a few percent of the beats are
	// stray statuses, loads, unused codes or aborting starts.
	task automatic test_random_traffic(input int budget);
		int sent;
		int r;
		sent = 0;
		while (sent < budget) begin
			r = $urandom_range(99);
			if (r < 25) begin
				repeat ($urandom_range(1, 4)) begin
					load_random_slot();
					sent++;
				end
			end else if (r < 30) begin
				send_status(8'($urandom), 8'($urandom));
				sent++;
			end
			random_start();
			sent++;
			while (transfer_open()) begin
				r = $urandom_range(99);
				if (r < 4)
					send_status(8'($urandom), 8'($urandom));
				else if (r < 6)
					load_random_slot();
				else if (r < 7)
					send_unused(3'($urandom_range(5, 7)));
				else if (r < 8)
					random_start();
				else
					send_status(next_good_status(), 8'($urandom));
				// unused codes change no state in the block and are not counted
				if (r != 6)
					sent++;
			end
		end
	endtask

	// Receiver holds off for a long stretch while commands keep coming, so
	// the internal queue fills and the command side stalls.
	task automatic test_backpressure();
		idle_pct  = 0;
		stall_pct = 0;
		hold_req  = 1'b1;
		test_random_traffic(50);
	endtask

	// ------------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------------
	initial begin
		int waited;
		arst_n       = 1'b0;
		cmd.valid    = 1'b0;
		cmd.payload  = '0;
		idle_pct     = 0;
		stall_pct    = 0;
		hold_req     = 1'b0;
		error_count  = 0;
		result_count = 0;
		waited       = 0;

		// predictor reset state
		seq_phase   = PH_IDLE;
		seq_dir     = DIR_TX;
		seq_addr    = '0;
		tx_pos      = '0;
		tx_total    = '0;
		rx_left     = '0;
		rx_pos      = '0;
		then_read   = 1'b0;
		slot_loaded = '0;
		foreach (tx_bytes[i])
			tx_bytes[i] = '0;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part, no idling
		test_idle_codes();
		test_write_transfer();
		test_write_read_transfer();
		test_read_abort();

		// random part under the four idle mixes
		test_random_traffic(325);
		idle_pct = 68;
		test_random_traffic(325);
		idle_pct  = 0;
		stall_pct = 68;
		test_random_traffic(325);
		idle_pct  = 33;
		stall_pct = 33;
		test_random_traffic(325);
		test_backpressure();

		// drain: let every pending response come back, then a quiet tail
		cmd.valid <= 1'b0;
		stall_pct = 0;
		while (pending_responses.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		if (pending_responses.size() != 0)
			note_error($sformatf("%0d responses never arrived", pending_responses.size()));
		repeat (TAIL_CYCLES) @(posedge clk);

		if (error_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

// ----- files.f -----
rtl/i2cms_pkg.sv
rtl/i2cms_if.sv
rtl/i2cms_front.sv
rtl/i2cms_queue.sv
rtl/i2cms_back.sv
rtl/i2c_master_transfer_sequencer.sv
test/i2c_master_transfer_sequencer_tb.sv
